@@ rtl/u8dec_pkg.sv @@
// Shared constants, a result type and a helper function for the UTF-8 decoder.
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 32;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned LEFT_W = 3;
  localparam int unsigned PAY_W  = 6;

  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;
  localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            truncated;
  } result_t;

  // Count of leading one bits in a byte, 0 to 8.
  function automatic logic [LEN_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    priority casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/u8dec_if.sv @@
// Valid/ready channel interfaces for text bytes and decoded code points.
interface u8dec_byte_if
  import u8dec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8dec_cp_if
  import u8dec_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            truncated;

  modport source (output valid, output code_point, output truncated, input ready);
  modport sink   (input valid, input code_point, input truncated, output ready);
endinterface

@@ rtl/utf8_to_codepoint_decoder_top.sv @@
// UTF-8 byte stream to code point decoder, top level.
// Takes one text word per cycle when not stalled, and gives one code point word
// per completed character from a registered output. The decode state
// (bytes left, accumulator, skip flag) updates in the cycle a byte is taken,
// so bytes stream back to back at one per cycle. Results go to an output
// register backed by a one-word skid stage: the input keeps taking bytes
// while a result waits, and stalls only when both hold a result.
// Continuation tags are not checked; a NUL mid-sequence flushes a nonzero
// partial value marked truncated; a decoded zero drops bytes through the next
// NUL. The accumulator wraps at 32 bits. No clearing pass after reset.
module utf8_to_codepoint_decoder_top
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  u8dec_byte_if.sink  text,
  u8dec_cp_if.source  chars
);

  logic [LEFT_W-1:0] bytes_left, bytes_left_next;
  logic [CP_W-1:0]   accumulator, accumulator_next;
  logic              skip_to_end, skip_to_end_next;

  logic              out_valid;
  result_t           out_word;
  logic              skid_valid;
  result_t           skid_word;

  logic              accept;
  logic              has_res;
  result_t           res;
  logic [BYTE_W-1:0] b;
  logic [CP_W-1:0]   shifted;
  logic [LEN_W-1:0]  n;
  logic [BYTE_W-1:0] seed;

  assign b       = text.text_byte;
  assign accept  = text.valid && text.ready;
  assign shifted = {accumulator[CP_W-PAY_W-1:0], b[PAY_W-1:0]};
  assign n       = lead_ones(b);
  assign seed    = BYTE_MASK >> n;

  always_comb begin
    bytes_left_next  = bytes_left;
    accumulator_next = accumulator;
    skip_to_end_next = skip_to_end;
    has_res          = 1'b0;
    res              = '0;
    if (skip_to_end) begin
      if (b == NUL_BYTE) skip_to_end_next = 1'b0;
    end else if (bytes_left != '0) begin
      bytes_left_next  = '0;
      accumulator_next = '0;
      if (b == NUL_BYTE) begin
        if (accumulator != '0) begin
          has_res        = 1'b1;
          res.code_point = accumulator;
          res.truncated  = 1'b1;
        end
      end else if (bytes_left == LEFT_W'(1)) begin
        if (shifted != '0) begin
          has_res        = 1'b1;
          res.code_point = shifted;
        end else begin
          skip_to_end_next = 1'b1;
        end
      end else begin
        accumulator_next = shifted;
        bytes_left_next  = bytes_left - LEFT_W'(1);
      end
    end else if (b == NUL_BYTE) begin
      // end of string, nothing to emit
    end else if (!b[BYTE_W-1]) begin
      has_res        = 1'b1;
      res.code_point = CP_W'(b);
    end else if (n == LEN_W'(1)) begin
      // stray continuation byte: one-byte sequence
      if ((b & seed) != '0) begin
        has_res        = 1'b1;
        res.code_point = CP_W'(b & seed);
      end else begin
        skip_to_end_next = 1'b1;
      end
    end else begin
      accumulator_next = CP_W'(b & seed);
      bytes_left_next  = LEFT_W'(n - LEN_W'(1));
    end
  end

  assign text.ready       = !skid_valid;
  assign chars.valid      = out_valid;
  assign chars.code_point = out_word.code_point;
  assign chars.truncated  = out_word.truncated;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      accumulator <= '0;
      skip_to_end <= 1'b0;
      out_valid   <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (accept) begin
        bytes_left  <= bytes_left_next;
        accumulator <= accumulator_next;
        skip_to_end <= skip_to_end_next;
      end
      if (skid_valid) begin
        if (chars.ready) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end
      end else if (accept && has_res) begin
        if (out_valid && !chars.ready) begin
          skid_word  <= res;
          skid_valid <= 1'b1;
        end else begin
          out_word  <= res;
          out_valid <= 1'b1;
        end
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/u8dec_checker.sv @@
// Port-level checker for the UTF-8 decoder, bound to the top level.
module u8dec_checker
  import u8dec_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CP_W-1:0] code_point,
  input logic            truncated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(truncated))
    else $error("stalled code point word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending after reset");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result shown");

  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted byte");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> code_point != '0)
    else $error("zero code point emitted");

endmodule

bind utf8_to_codepoint_decoder_top u8dec_checker u_u8dec_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (text.valid),
  .in_ready   (text.ready),
  .out_valid  (chars.valid),
  .out_ready  (chars.ready),
  .code_point (chars.code_point),
  .truncated  (chars.truncated)
);

@@ test/testbench.sv @@
// Testbench for the UTF-8 to code point decoder: directed strings, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import u8dec_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 900;

  logic clk;
  logic rst;

  u8dec_byte_if text_ch ();
  u8dec_cp_if   chars_ch ();

  utf8_to_codepoint_decoder_top dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .chars (chars_ch)
  );

  // decoder state mirror
  logic [LEFT_W-1:0] cont_left;
  logic [CP_W-1:0]   partial_cp;
  logic              skipping;

  result_t pending_chars[$];
  int      mismatches;
  int      bytes_sent;
  int      idle_cycles;
  int      stall_left;
  bit      throttle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic void expect_char(logic [CP_W-1:0] cp, logic cut);
    result_t r;
    r.code_point = cp;
    r.truncated  = cut;
    pending_chars.push_back(r);
  endfunction

  function automatic void close_char();
    if (partial_cp != '0) expect_char(partial_cp, 1'b0);
    else skipping = 1'b1;
    partial_cp = '0;
    cont_left  = '0;
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b);
    int n;
    logic [BYTE_W-1:0] probe;
    if (skipping) begin
      if (b == NUL_BYTE) skipping = 1'b0;
      return;
    end
    if (cont_left != '0) begin
      if (b == NUL_BYTE) begin
        if (partial_cp != '0) expect_char(partial_cp, 1'b1);
        partial_cp = '0;
        cont_left  = '0;
        return;
      end
      partial_cp = {partial_cp[CP_W-PAY_W-1:0], b[PAY_W-1:0]};
      cont_left  = cont_left - LEFT_W'(1);
      if (cont_left == '0) close_char();
      return;
    end
    if (b == NUL_BYTE) return;
    if (!b[7]) begin
      expect_char(CP_W'(b), 1'b0);
      return;
    end
    n = 0;
    probe = b;
    while (probe[7] && n < 8) begin
      probe = probe << 1;
      n++;
    end
    partial_cp = CP_W'(b & (BYTE_MASK >> n));
    cont_left  = LEFT_W'(n - 1);
    if (cont_left == '0) close_char();
  endfunction

  task automatic report_mismatch(string what, logic [CP_W-1:0] got, logic [CP_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = throttle ? gap_len() : 0;
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  // lead byte for a sequence of len bytes, then continuation words;
  // a cut sequence stops early with a NUL
  task automatic send_char(int len, bit cut);
    logic [BYTE_W-1:0] lead;
    int conts;
    if (len >= 8) lead = 8'hFF;
    else lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
    conts = cut ? $urandom_range(0, len - 2) : len - 1;
    send_byte(lead);
    repeat (conts) send_byte(8'h80 | 8'($urandom_range(0, 63)));
    if (cut) send_byte(NUL_BYTE);
  endtask

  task automatic drain();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_ascii();
    throttle = 1'b0;
    send_byte(8'h41); send_byte(8'h7F); send_byte(8'h01); send_byte(NUL_BYTE);
  endtask

  task automatic test_multibyte();
    throttle = 1'b1;
    send_byte(8'hC3); send_byte(8'hA9);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
    send_byte(8'hBF);
    drain();
  endtask

  task automatic test_special_cases();
    // stray continuation decodes to zero: skip through NUL
    send_byte(8'h80); send_byte(8'h41); send_byte(NUL_BYTE);
    // NUL cuts a nonzero partial, then a zero partial
    send_byte(8'hE2); send_byte(8'h82); send_byte(NUL_BYTE);
    send_byte(8'hE0); send_byte(NUL_BYTE);
    // eight-byte lead with full payloads wraps at 32 bits
    send_byte(8'hFF);
    repeat (7) send_byte(8'hBF);
    send_byte(NUL_BYTE);
  endtask

  task automatic test_random();
    int r;
    int block;
    block = -1;
    while (bytes_sent < RANDOM_WORDS + 30) begin
      if (bytes_sent / 100 != block) begin
        block = bytes_sent / 100;
        throttle = ($urandom_range(0, 3) != 0);
        if (block == 4) drain();
      end
      r = $urandom_range(0, 99);
      if (r < 30) send_byte(8'($urandom_range(1, 127)));
      else if (r < 65) send_char($urandom_range(2, 4), 1'b0);
      else if (r < 72) send_char($urandom_range(5, 8), 1'b0);
      else if (r < 80) send_char($urandom_range(2, 8), 1'b1);
      else if (r < 90) send_byte(NUL_BYTE);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      chars_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      chars_ch.ready <= 1'b0;
    end else if (throttle && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      chars_ch.ready <= 1'b0;
    end else begin
      chars_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && chars_ch.valid && chars_ch.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected code point", chars_ch.code_point, '0);
      end else begin
        want = pending_chars.pop_front();
        if (chars_ch.code_point !== want.code_point)
          report_mismatch("code_point", chars_ch.code_point, want.code_point);
        if (chars_ch.truncated !== want.truncated)
          report_mismatch("truncated", CP_W'(chars_ch.truncated), CP_W'(want.truncated));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (chars_ch.valid && chars_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    throttle = 1'b0;
    bytes_sent = 0;
    cont_left = '0;
    partial_cp = '0;
    skipping = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii();
    test_multibyte();
    test_special_cases();
    test_random();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
